### rtl/detection_box_decode_macros.svh
// Assertion macros used by the checker file.
`ifndef DETECTION_BOX_DECODE_MACROS_SVH
`define DETECTION_BOX_DECODE_MACROS_SVH

// Implication in the same cycle, ignored while reset is asserted.
`define DBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("detection_box_decode check failed");

// Implication in the next cycle, ignored while reset is asserted.
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("detection_box_decode check failed");

// Implication in the next cycle that is also checked during reset.
`define DBD_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("detection_box_decode check failed");

`endif

### rtl/dbd_pkg.sv
package dbd_pkg;

  localparam int NUM_CLASSES = 5;
  localparam int CLS_W       = 3;
  localparam int SCORE_W     = 16;
  localparam int COORD_W     = 14;
  localparam int PAD_W       = 10;
  localparam int FRAME_W     = 13;
  localparam int EDGE_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Signed Q.5 edge before scaling, and its magnitude.
  localparam int Q5_W  = 18;
  localparam int MAG_W = 16;
  localparam int PROD_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_INV_SCALE = 3'd1,
    CFG_PAD_X     = 3'd2,
    CFG_PAD_Y     = 3'd3,
    CFG_FRAME_W   = 3'd4,
    CFG_FRAME_H   = 3'd5,
    CFG_CLASSES   = 3'd6
  } cfg_reg_t;

  localparam logic [15:0]        RST_THRESHOLD = 16'd16384;
  localparam logic [15:0]        RST_INV_SCALE = 16'd4096;
  localparam logic [PAD_W-1:0]   RST_PAD       = '0;
  localparam logic [FRAME_W-1:0] RST_FRAME_W   = 13'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_H   = 13'd480;
  localparam logic [CLS_W-1:0]   RST_CLASSES   = 3'd5;

  // Load enables of the three internal pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_ctl_t;

endpackage

### rtl/detection_box_decode.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    centre, size, objectness, class scores
// out_      output     out_valid/out_stall  box edges, class index, confidence
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// One row is accepted per cycle while in_stall is low. A kept row is offered on
// out_valid once it has passed the operand registers, the registered 16x16 multiply
// in each edge lane and in the score path, rounding and clamping, then the output
// register. Rejected rows leave a bubble.
// Reset clears the stage valid bits and loads the register defaults.
// A stall on the output backs up only as far as the pipeline is full.
module detection_box_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dbd_pkg::COORD_W-1:0]     in_center_x,
  input  logic [dbd_pkg::COORD_W-1:0]     in_center_y,
  input  logic [dbd_pkg::COORD_W-1:0]     in_box_width,
  input  logic [dbd_pkg::COORD_W-1:0]     in_box_height,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_objectness,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_class_score_0,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_class_score_1,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_class_score_2,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_class_score_3,
  input  logic [dbd_pkg::SCORE_W-1:0]     in_class_score_4,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dbd_pkg::EDGE_W-1:0]      out_left_edge,
  output logic [dbd_pkg::EDGE_W-1:0]      out_top_edge,
  output logic [dbd_pkg::EDGE_W-1:0]      out_right_edge,
  output logic [dbd_pkg::EDGE_W-1:0]      out_bottom_edge,
  output logic [dbd_pkg::CLS_W-1:0]       out_class_index,
  output logic [dbd_pkg::SCORE_W-1:0]     out_confidence,
  input  logic                            cfg_we,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dbd_pkg::*;

  logic [15:0]        threshold_r;
  logic [15:0]        inv_scale_r;
  logic [PAD_W-1:0]   pad_x_r;
  logic [PAD_W-1:0]   pad_y_r;
  logic [FRAME_W-1:0] frame_w_r;
  logic [FRAME_W-1:0] frame_h_r;
  logic [CLS_W-1:0]   classes_r;

  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic               out_free;
  logic               en1;
  logic               en2;
  logic               en3;
  stage_ctl_t         ctl;

  logic [SCORE_W-1:0] scores [NUM_CLASSES];
  logic               pass;
  logic [CLS_W-1:0]   cls3;
  logic [SCORE_W-1:0] conf3;
  logic [EDGE_W-1:0]  x1;
  logic [EDGE_W-1:0]  y1;
  logic [EDGE_W-1:0]  x2;
  logic [EDGE_W-1:0]  y2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= RST_THRESHOLD;
      inv_scale_r <= RST_INV_SCALE;
      pad_x_r     <= RST_PAD;
      pad_y_r     <= RST_PAD;
      frame_w_r   <= RST_FRAME_W;
      frame_h_r   <= RST_FRAME_H;
      classes_r   <= RST_CLASSES;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD: threshold_r <= cfg_data;
        CFG_INV_SCALE: inv_scale_r <= cfg_data;
        CFG_PAD_X:     pad_x_r     <= cfg_data[PAD_W-1:0];
        CFG_PAD_Y:     pad_y_r     <= cfg_data[PAD_W-1:0];
        CFG_FRAME_W:   frame_w_r   <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_H:   frame_h_r   <= cfg_data[FRAME_W-1:0];
        CFG_CLASSES:   classes_r   <= cfg_data[CLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  assign en3      = !v3_r || out_free;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign ctl      = {en1, en2, en3};
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign scores[0] = in_class_score_0;
  assign scores[1] = in_class_score_1;
  assign scores[2] = in_class_score_2;
  assign scores[3] = in_class_score_3;
  assign scores[4] = in_class_score_4;

  dbd_score_select u_score (
    .clk            (clk),
    .ctl            (ctl),
    .objectness     (in_objectness),
    .scores         (scores),
    .threshold      (threshold_r),
    .classes_in_use (classes_r),
    .pass_r         (pass),
    .cls3_r         (cls3),
    .conf_r         (conf3)
  );

  dbd_edge_lane u_lane_x1 (
    .clk (clk), .ctl (ctl), .is_low (1'b1),
    .center (in_center_x), .size (in_box_width), .pad (pad_x_r),
    .inv_scale (inv_scale_r), .frame_size (frame_w_r), .edge_r (x1)
  );

  dbd_edge_lane u_lane_y1 (
    .clk (clk), .ctl (ctl), .is_low (1'b1),
    .center (in_center_y), .size (in_box_height), .pad (pad_y_r),
    .inv_scale (inv_scale_r), .frame_size (frame_h_r), .edge_r (y1)
  );

  dbd_edge_lane u_lane_x2 (
    .clk (clk), .ctl (ctl), .is_low (1'b0),
    .center (in_center_x), .size (in_box_width), .pad (pad_x_r),
    .inv_scale (inv_scale_r), .frame_size (frame_w_r), .edge_r (x2)
  );

  dbd_edge_lane u_lane_y2 (
    .clk (clk), .ctl (ctl), .is_low (1'b0),
    .center (in_center_y), .size (in_box_height), .pad (pad_y_r),
    .inv_scale (inv_scale_r), .frame_size (frame_h_r), .edge_r (y2)
  );

  dbd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid3      (v3_r),
    .pass        (pass),
    .x1          (x1),
    .y1          (y1),
    .x2          (x2),
    .y2          (y2),
    .cls         (cls3),
    .conf        (conf3),
    .out_stall   (out_stall),
    .out_free    (out_free),
    .out_valid_r (out_valid),
    .left_r      (out_left_edge),
    .top_r       (out_top_edge),
    .right_r     (out_right_edge),
    .bottom_r    (out_bottom_edge),
    .cls_r       (out_class_index),
    .conf_out_r  (out_confidence)
  );

endmodule

### rtl/dbd_edge_lane.sv
module dbd_edge_lane (
  input  logic                          clk,
  input  dbd_pkg::stage_ctl_t           ctl,
  input  logic                          is_low,
  input  logic [dbd_pkg::COORD_W-1:0]   center,
  input  logic [dbd_pkg::COORD_W-1:0]   size,
  input  logic [dbd_pkg::PAD_W-1:0]     pad,
  input  logic [15:0]                   inv_scale,
  input  logic [dbd_pkg::FRAME_W-1:0]   frame_size,
  output logic [dbd_pkg::EDGE_W-1:0]    edge_r
);
  import dbd_pkg::*;

  logic signed [Q5_W-1:0] q5;
  logic signed [Q5_W-1:0] q5_neg;
  logic [Q5_W-1:0]        q5_abs;
  logic [MAG_W-1:0]       mag_r;
  logic                   neg_r;
  logic [PROD_W-1:0]      prod_r;
  logic                   neg2_r;
  logic [PROD_W:0]        rsum;
  logic [MAG_W-1:0]       rounded;
  logic [EDGE_W-1:0]      hi;
  logic [EDGE_W-1:0]      edge_nxt;

  // Edge in Q.5: 2*centre -/+ size - 32*pad.
  assign q5 = $signed({3'b000, center, 1'b0})
            + (is_low ? -$signed({4'b0000, size}) : $signed({4'b0000, size}))
            - $signed({3'b000, pad, 5'b00000});
  assign q5_neg = -q5;
  assign q5_abs = q5[Q5_W-1] ? q5_neg : q5;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      mag_r <= q5_abs[MAG_W-1:0];
      neg_r <= q5[Q5_W-1];
    end
    if (ctl.en2) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(inv_scale);
      neg2_r <= neg_r;
    end
    if (ctl.en3) begin
      edge_r <= edge_nxt;
    end
  end

  // Round half away from zero on the magnitude, Q.17 to integer.
  assign rsum    = {1'b0, prod_r} + (PROD_W+1)'(33'h1_0000);
  assign rounded = rsum[PROD_W:17];

  // Upper clamp limit is min(frame - 1, 4095).
  assign hi = (frame_size > FRAME_W'(4096)) ? {EDGE_W{1'b1}}
                                            : EDGE_W'(frame_size - FRAME_W'(1));

  always_comb begin
    if (neg2_r || frame_size == '0) begin
      edge_nxt = '0;
    end else if (rounded > MAG_W'(hi)) begin
      edge_nxt = hi;
    end else begin
      edge_nxt = rounded[EDGE_W-1:0];
    end
  end

endmodule

### rtl/dbd_score_select.sv
module dbd_score_select (
  input  logic                          clk,
  input  dbd_pkg::stage_ctl_t           ctl,
  input  logic [dbd_pkg::SCORE_W-1:0]   objectness,
  input  logic [dbd_pkg::SCORE_W-1:0]   scores [dbd_pkg::NUM_CLASSES],
  input  logic [15:0]                   threshold,
  input  logic [dbd_pkg::CLS_W-1:0]     classes_in_use,
  output logic                          pass_r,
  output logic [dbd_pkg::CLS_W-1:0]     cls3_r,
  output logic [dbd_pkg::SCORE_W-1:0]   conf_r
);
  import dbd_pkg::*;

  logic [SCORE_W-1:0] best;
  logic [CLS_W-1:0]   cls;
  logic               found;
  logic [SCORE_W-1:0] best_r;
  logic [SCORE_W-1:0] obj_r;
  logic [CLS_W-1:0]   cls1_r;
  logic               found1_r;
  logic [PROD_W-1:0]  prod_r;
  logic [CLS_W-1:0]   cls2_r;
  logic               found2_r;
  logic               pass_nxt;

  // Strict greater-than keeps the first of equal scores; zero never wins.
  always_comb begin
    best  = '0;
    cls   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (scores[i] > best) begin
        best  = scores[i];
        cls   = CLS_W'(i);
        found = 1'b1;
      end
    end
  end

  assign pass_nxt = found2_r && (cls2_r < classes_in_use)
                 && (prod_r >= {threshold, 16'h0000});

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      best_r   <= best;
      obj_r    <= objectness;
      cls1_r   <= cls;
      found1_r <= found;
    end
    if (ctl.en2) begin
      prod_r   <= PROD_W'(obj_r) * PROD_W'(best_r);
      cls2_r   <= cls1_r;
      found2_r <= found1_r;
    end
    if (ctl.en3) begin
      pass_r <= pass_nxt;
      cls3_r <= cls2_r;
      conf_r <= prod_r[PROD_W-1:16];
    end
  end

endmodule

### rtl/dbd_merge.sv
module dbd_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid3,
  input  logic                          pass,
  input  logic [dbd_pkg::EDGE_W-1:0]    x1,
  input  logic [dbd_pkg::EDGE_W-1:0]    y1,
  input  logic [dbd_pkg::EDGE_W-1:0]    x2,
  input  logic [dbd_pkg::EDGE_W-1:0]    y2,
  input  logic [dbd_pkg::CLS_W-1:0]     cls,
  input  logic [dbd_pkg::SCORE_W-1:0]   conf,
  input  logic                          out_stall,
  output logic                          out_free,
  output logic                          out_valid_r,
  output logic [dbd_pkg::EDGE_W-1:0]    left_r,
  output logic [dbd_pkg::EDGE_W-1:0]    top_r,
  output logic [dbd_pkg::EDGE_W-1:0]    right_r,
  output logic [dbd_pkg::EDGE_W-1:0]    bottom_r,
  output logic [dbd_pkg::CLS_W-1:0]     cls_r,
  output logic [dbd_pkg::SCORE_W-1:0]   conf_out_r
);
  import dbd_pkg::*;

  logic keep;

  assign out_free = !out_valid_r || !out_stall;
  // Empty boxes are dropped here along with rows that failed scoring.
  assign keep     = pass && (x2 > x1) && (y2 > y1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= valid3 && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && valid3) begin
      left_r     <= x1;
      top_r      <= y1;
      right_r    <= x2;
      bottom_r   <= y2;
      cls_r      <= cls;
      conf_out_r <= conf;
    end
  end

endmodule

### rtl/dbd_checker.sv
`include "detection_box_decode_macros.svh"

module dbd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [dbd_pkg::EDGE_W-1:0]      out_left_edge,
  input  logic [dbd_pkg::EDGE_W-1:0]      out_top_edge,
  input  logic [dbd_pkg::EDGE_W-1:0]      out_right_edge,
  input  logic [dbd_pkg::EDGE_W-1:0]      out_bottom_edge,
  input  logic [dbd_pkg::CLS_W-1:0]       out_class_index,
  input  logic [dbd_pkg::SCORE_W-1:0]     out_confidence
);
  import dbd_pkg::*;

  // A stalled result transaction stays offered with the same payload.
  `DBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable({out_left_edge, out_top_edge, out_right_edge,
                                         out_bottom_edge, out_class_index, out_confidence}))

  // A stalled input transaction stays offered.
  `DBD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)

  // Every delivered box has positive width and height.
  `DBD_ASSERT_NOW(a_box_nonempty, clk, rst_n, out_valid,
                  (out_right_edge > out_left_edge) && (out_bottom_edge > out_top_edge))

  // Only a class that the row can carry is reported.
  `DBD_ASSERT_NOW(a_class_range, clk, rst_n, out_valid,
                  out_class_index < CLS_W'(NUM_CLASSES))

  // Nothing is offered in the cycle after reset.
  `DBD_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind detection_box_decode dbd_checker u_dbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left_edge   (out_left_edge),
  .out_top_edge    (out_top_edge),
  .out_right_edge  (out_right_edge),
  .out_bottom_edge (out_bottom_edge),
  .out_class_index (out_class_index),
  .out_confidence  (out_confidence)
);
